// ===== design/disk_block_address_translate_unit_macros.svh =====
// Assertion macros shared by the disk block address translation design
`ifndef DISK_BLOCK_ADDRESS_TRANSLATE_UNIT_MACROS_SVH
`define DISK_BLOCK_ADDRESS_TRANSLATE_UNIT_MACROS_SVH

// Property checked on every rising clk edge outside reset
`define DBAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked in the same cycle
`define DBAT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ===== design/dbat_pkg.sv =====
// Types, constants and partition tables for the disk block address translation unit
`timescale 1ns / 1ps
`default_nettype none

package dbat_pkg;

  localparam int UNIT_COUNT      = 2;
  localparam int SEARCH_DISTANCE = 2;
  localparam int ROTATE_DISTANCE = 6;

  localparam int NSECT   = 22;
  localparam int NTRAC   = 19;
  localparam int NRMSECT = 32;
  localparam int NRMTRAC = 5;

  localparam logic [3:0] UNIT_LIMIT = 4'(UNIT_COUNT);

  // Sectors per cylinder: 418 = 2 * 209 and 160 = 32 * 5, so the block number
  // is shifted first and the remaining divide uses a reciprocal.
  localparam int          RECIP_SHIFT = 20;
  localparam logic [17:0] RECIP_RP    = 18'((1 << RECIP_SHIFT) / ((NSECT * NTRAC) / 2));
  localparam logic [17:0] RECIP_RM    = 18'((1 << RECIP_SHIFT) / NRMTRAC);
  localparam logic [7:0]  DIV_RP      = 8'((NSECT * NTRAC) / 2);
  localparam logic [7:0]  DIV_RM      = 8'(NRMTRAC);

  // Track split for the 22-sector type: remainder / (NSECT / 2)
  localparam int          TRK_SHIFT = 8;
  localparam logic [4:0]  TRK_RECIP = 5'((1 << TRK_SHIFT) / (NSECT / 2));
  localparam logic [3:0]  TRK_DIV   = 4'(NSECT / 2);

  localparam logic [5:0] NS_RP = 6'(NSECT);
  localparam logic [5:0] NS_RM = 6'(NRMSECT);

  typedef enum logic [0:0] {
    CFG_UNIT0_IS_RM = 1'b0,
    CFG_UNIT1_IS_RM = 1'b1
  } cfg_reg_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic        err;
    logic        rm;
    logic [17:0] x;       // block number shifted by the cylinder factor
    logic [4:0]  low;     // low block number bits
    logic [7:0]  base;    // partition cylinder offset
    logic [15:0] curcyl;
    logic [9:0]  look;
  } req_t;

  // Work record carried down the back pipeline
  typedef struct packed {
    req_t        req;
    logic [15:0] q;
    logic [7:0]  r;
    logic [4:0]  tq;
    logic [12:0] cyl;
    logic [4:0]  trk;
    logic [4:0]  sec;
  } work_t;

  function automatic logic [18:0] part_blocks(input logic rm, input logic [2:0] part);
    logic [18:0] b;
    b = '0;
    if (rm) begin
      case (part)
        3'd0:    b = 19'd9600;
        3'd1:    b = 19'd8800;
        3'd6:    b = 19'd122080;
        3'd7:    b = 19'd113280;
        default: b = '0;
      endcase
    end else begin
      case (part)
        3'd0:    b = 19'd9614;
        3'd1:    b = 19'd8778;
        3'd2:    b = 19'd35948;
        3'd3:    b = 19'd286330;
        3'd6:    b = 19'd330220;
        3'd7:    b = 19'd322278;
        default: b = '0;
      endcase
    end
    return b;
  endfunction

  function automatic logic [7:0] part_base(input logic rm, input logic [2:0] part);
    logic [7:0] c;
    c = '0;
    if (rm) begin
      case (part)
        3'd1:    c = 8'd60;
        3'd6:    c = 8'd60;
        3'd7:    c = 8'd115;
        default: c = '0;
      endcase
    end else begin
      case (part)
        3'd1:    c = 8'd23;
        3'd2:    c = 8'd44;
        3'd3:    c = 8'd130;
        3'd6:    c = 8'd25;
        3'd7:    c = 8'd44;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/dbat_front.sv =====
// Front end: configuration registers, geometry pick and range check
`timescale 1ns / 1ps
`default_nettype none

module dbat_front import dbat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [0:0]  cfg_data,
  input  wire logic [67:0] in_data,
  output req_t             req
);

  logic        unit0_is_rm;
  logic        unit1_is_rm;
  logic [2:0]  unit;
  logic [2:0]  part;
  logic [19:0] braw;
  logic [15:0] bytes;
  logic        rm;
  logic [16:0] bytes_up;
  logic [7:0]  nblk;
  logic [19:0] blk_end;
  logic [18:0] blocks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit0_is_rm <= 1'b0;
      unit1_is_rm <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_UNIT0_IS_RM: unit0_is_rm <= cfg_data[0];
        CFG_UNIT1_IS_RM: unit1_is_rm <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign unit  = in_data[2:0];
  assign part  = in_data[5:3];
  assign braw  = in_data[25:6];
  assign bytes = in_data[41:26];

  always_comb begin
    rm       = 1'b0;
    if (unit == 3'd0)
      rm = unit0_is_rm;
    else if (unit == 3'd1)
      rm = unit1_is_rm;
    bytes_up = {1'b0, bytes} + 17'd511;
    nblk     = bytes_up[16:9];
    blk_end  = {1'b0, braw[18:0]} + {12'd0, nblk};
    blocks   = part_blocks(rm, part);

    req.err    = ({1'b0, unit} >= UNIT_LIMIT) || braw[19] || (blk_end > {1'b0, blocks});
    req.rm     = rm;
    req.x      = rm ? {4'd0, braw[18:5]} : braw[18:1];
    req.low    = braw[4:0];
    req.base   = part_base(rm, part);
    req.curcyl = in_data[57:42];
    req.look   = in_data[67:58];
  end

endmodule

`default_nettype wire

// ===== design/dbat_queue.sv =====
// Two-entry queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module dbat_queue import dbat_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  req_t      push_req,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output req_t      head_req
);

  req_t       slot0;
  req_t       slot1;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_req   = rptr ? slot1 : slot0;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push)
        wptr <= !wptr;
      if (do_pop)
        rptr <= !rptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      if (wptr)
        slot1 <= push_req;
      else
        slot0 <= push_req;
    end
  end

endmodule

`default_nettype wire

// ===== design/dbat_back.sv =====
// Back end: divide pipeline, sector split, search sector and output register
`timescale 1ns / 1ps
`default_nettype none

module dbat_back import dbat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  req_t             head_req,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_data,
  output logic [0:0]       out_user
);

  work_t st1, st2, st3, st4;
  work_t st1_next, st2_next, st3_next, st4_next;
  logic  v1, v2, v3, v4;
  logic  en1, en2, en3, en4, en5;

  // stage 1
  logic [35:0] prod;
  // stage 2
  logic [7:0]  dv;
  logic [23:0] qd;
  logic [17:0] rdiff;
  logic [8:0]  r0;
  // stage 3
  logic [12:0] tprod;
  // stage 4
  logic [8:0]  tqd;
  logic [7:0]  r2diff;
  logic [4:0]  r2;
  logic [3:0]  r2c;
  // stage 5
  logic [5:0]  ns;
  logic [5:0]  srch_raw;
  logic [5:0]  srch;
  logic signed [11:0] rot_gap;
  logic signed [11:0] rot_gap_w;
  logic signed [11:0] win;
  logic        need;

  // advance a stage when it is empty or the one after it moves on
  assign en5 = !out_valid || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = en1 && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= head_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // quotient estimate, low by at most one
  always_comb begin
    prod         = 36'(head_req.x) * 36'(head_req.rm ? RECIP_RM : RECIP_RP);
    st1_next     = '0;
    st1_next.req = head_req;
    st1_next.q   = prod[35:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (en1)
      st1 <= st1_next;
  end

  // correct the estimate against the remainder
  always_comb begin
    dv       = st1.req.rm ? DIV_RM : DIV_RP;
    qd       = 24'(st1.q) * 24'(dv);
    rdiff    = st1.req.x - qd[17:0];
    r0       = rdiff[8:0];
    st2_next = st1;
    if (r0 >= {1'b0, dv}) begin
      st2_next.q = st1.q + 16'd1;
      st2_next.r = 8'(r0 - {1'b0, dv});
    end else begin
      st2_next.r = r0[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2)
      st2 <= st2_next;
  end

  // cylinder and track estimate for the 22-sector type
  always_comb begin
    tprod        = 13'(st2.r) * 13'(TRK_RECIP);
    st3_next     = st2;
    st3_next.cyl = st2.q[12:0] + {5'd0, st2.req.base};
    st3_next.tq  = tprod[12:TRK_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (en3)
      st3 <= st3_next;
  end

  always_comb begin
    tqd      = 9'(st3.tq) * 9'(TRK_DIV);
    r2diff   = st3.r - tqd[7:0];
    r2       = r2diff[4:0];
    r2c      = (r2 >= {1'b0, TRK_DIV}) ? 4'(r2 - {1'b0, TRK_DIV}) : r2[3:0];
    st4_next = st3;
    if (st3.req.rm) begin
      st4_next.trk = st3.r[4:0];
      st4_next.sec = st3.req.low;
    end else begin
      st4_next.trk = (r2 >= {1'b0, TRK_DIV}) ? st3.tq + 5'd1 : st3.tq;
      st4_next.sec = {r2c, st3.req.low[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en4)
      st4 <= st4_next;
  end

  // search sector and rotational window
  always_comb begin
    ns        = st4.req.rm ? NS_RM : NS_RP;
    srch_raw  = {1'b0, st4.sec} + ns - 6'(SEARCH_DISTANCE);
    srch      = (srch_raw >= ns) ? srch_raw - ns : srch_raw;
    rot_gap   = $signed({2'b00, st4.req.look}) - $signed({6'd0, srch})
                + 12'(SEARCH_DISTANCE) - 12'sd1;
    rot_gap_w = (rot_gap < 0) ? rot_gap + $signed({6'd0, ns}) : rot_gap;
    win       = $signed({6'd0, ns}) - 12'(ROTATE_DISTANCE);
    if ({3'd0, st4.cyl} != st4.req.curcyl)
      need = 1'b1;
    else
      need = !(rot_gap_w > win);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_user[0] <= st4.req.err;
      if (st4.req.err)
        out_data <= '0;
      else
        out_data <= {4'd0, need, srch[4:0], st4.sec, st4.trk, st4.cyl[11:0]};
    end
  end

endmodule

`default_nettype wire

// ===== design/disk_block_address_translate_unit.sv =====
// Top level of the disk block address translation unit
//
// Channel  Dir  Handshake              Contents
// s_*      in   s_tvalid / s_tready    request beat
// m_*      out  m_tvalid / m_tready    translated address beat
// cfg_*    in   cfg_valid / cfg_ready  geometry register write
//
// One request per cycle is sustained while the output is not stalled. A taken beat
// sits in the two-entry queue, then goes through reciprocal multiply, quotient
// correction, cylinder add and track split, with the search window settling into
// the output register. Reset clears the geometry registers, queue pointers and
// pipeline valids. A stalled output backs up the pipeline, then the queue, then
// s_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "disk_block_address_translate_unit_macros.svh"

module disk_block_address_translate_unit import dbat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // drive_unit, partition, block_number, byte_count, current_cylinder, lookahead_sector
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cylinder, track, sector, search_sector, need_search
  output logic [31:0]      m_tdata,
  // address_error
  output logic [0:0]       m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [0:0]  cfg_data
);

  req_t front_req;
  req_t head_req;
  logic q_full;
  logic head_valid;
  logic pop;

  assign s_tready = !q_full;

  dbat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata[67:0]),
    .req       (front_req)
  );

  dbat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_req   (front_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  dbat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_user   (m_tuser)
  );

  `DBAT_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser[0], m_tdata == 32'd0, "rejected beat carries data")
  `DBAT_ASSERT_IMP(a_full_has_head, !s_tready, head_valid, "queue full but empty")
  `DBAT_ASSERT_IMP(a_search_moves, m_tvalid && !m_tuser[0] && (SEARCH_DISTANCE != 0), m_tdata[26:22] != m_tdata[21:17], "search sector equals target")
  `DBAT_ASSERT(a_out_hold, !$past(m_tvalid && !m_tready) || (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result beat changed while stalled")

endmodule

`default_nettype wire

// ===== verif/dbat_address_checker.sv =====
// Scoreboard that predicts and checks every translated address beat
`timescale 1ns / 1ps

module dbat_address_checker import dbat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  output int          fail_count,
  output int          results_done,
  output int          backlog
);

  // Partition sizes and cylinder offsets per drive type
  int unsigned rp_span [8] = '{9614, 8778, 35948, 286330, 0, 0, 330220, 322278};
  int unsigned rp_base [8] = '{0, 23, 44, 130, 0, 0, 25, 44};
  int unsigned rm_span [8] = '{9600, 8800, 0, 0, 0, 0, 122080, 113280};
  int unsigned rm_base [8] = '{0, 60, 0, 0, 0, 0, 60, 115};

  bit unit0_rm;
  bit unit1_rm;

  // Each entry is {address_error, m_tdata}
  logic [32:0] addr_expected_q [$];

  function automatic logic [32:0] translate_block_address(input logic [71:0] req);
    logic [2:0]  unit;
    logic [2:0]  part;
    logic [19:0] blk;
    logic [15:0] bytes;
    logic [15:0] curcyl;
    logic [9:0]  look;
    bit          rm;
    int unsigned span, base, ns, per_cyl, nblk, cyl, cyl_off, trk, sec, srch;
    int          head_gap;
    bit          need;
    unit   = req[2:0];
    part   = req[5:3];
    blk    = req[25:6];
    bytes  = req[41:26];
    curcyl = req[57:42];
    look   = req[67:58];
    rm = (unit == 3'd0) ? unit0_rm : (unit == 3'd1) ? unit1_rm : 1'b0;
    span    = rm ? rm_span[part] : rp_span[part];
    base    = rm ? rm_base[part] : rp_base[part];
    ns      = rm ? NRMSECT : NSECT;
    per_cyl = rm ? NRMSECT * NRMTRAC : NSECT * NTRAC;
    nblk = (32'(bytes) + 32'd511) >> 9;
    if (32'(unit) >= UNIT_COUNT || blk[19] || 32'(blk) + nblk > span)
      return {1'b1, 32'd0};
    cyl     = 32'(blk) / per_cyl + base;
    cyl_off = 32'(blk) % per_cyl;
    trk     = cyl_off / ns;
    sec     = cyl_off % ns;
    srch    = (sec + ns - SEARCH_DISTANCE) % ns;
    if (cyl != 32'(curcyl)) begin
      need = 1'b1;
    end else begin
      // head position relative to the search sector, wrapped once
      head_gap = int'(32'(look)) - int'(srch) + SEARCH_DISTANCE - 1;
      if (head_gap < 0) head_gap = head_gap + int'(ns);
      need = !(head_gap > int'(ns) - ROTATE_DISTANCE);
    end
    return {1'b0, 4'd0, need, srch[4:0], sec[4:0], trk[4:0], cyl[11:0]};
  endfunction

  function automatic int field_diff(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    logic [32:0] want;
    logic [32:0] got;
    int          errs;
    if (rst) begin
      unit0_rm = 1'b0;
      unit1_rm = 1'b0;
      addr_expected_q.delete();
      fail_count = 0;
      results_done <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_UNIT0_IS_RM: unit0_rm = cfg_data[0];
          CFG_UNIT1_IS_RM: unit1_rm = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        addr_expected_q.push_back(translate_block_address(s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata};
        results_done <= results_done + 1;
        if (addr_expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, got);
          fail_count = fail_count + 1;
        end else begin
          want = addr_expected_q.pop_front();
          errs = field_diff("address_error", want[32], got[32])
               + field_diff("cylinder", want[11:0], got[11:0])
               + field_diff("track", want[16:12], got[16:12])
               + field_diff("sector", want[21:17], got[21:17])
               + field_diff("search_sector", want[26:22], got[26:22])
               + field_diff("need_search", want[27], got[27])
               + field_diff("tdata padding", want[31:28], got[31:28]);
          if (errs != 0) fail_count = fail_count + 1;
        end
      end
    end
    backlog = addr_expected_q.size();
  end

endmodule

// ===== verif/disk_block_address_translate_unit_tb.sv =====
// Stimulus and verdict for the disk block address translation unit
`timescale 1ns / 1ps

module disk_block_address_translate_unit_tb;
  import dbat_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 410;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [0:0]  cfg_data;

  int fail_count;
  int results_done;
  int backlog;
  int issued;
  int cycles;
  bit rush;
  bit geo0;
  bit geo1;

  disk_block_address_translate_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dbat_address_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_done (results_done),
    .backlog      (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stall before each beat
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_request(input logic [2:0] unit, input logic [2:0] part,
                              input logic [19:0] blk, input logic [15:0] bytes,
                              input logic [15:0] curcyl, input logic [9:0] look);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, look, curcyl, bytes, blk, part, unit};
    do @(posedge clk); while (!s_tready);
    issued = issued + 1;
  endtask

  task automatic wait_drained();
    while (results_done != issued) @(posedge clk);
  endtask

  task automatic write_geometry(input bit g0, input bit g1);
    // drop the request valid so the held beat is not taken twice
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_UNIT0_IS_RM;
    cfg_data  <= g0;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_UNIT1_IS_RM;
    cfg_data  <= g1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    geo0 = g0;
    geo1 = g1;
  endtask

  task automatic random_request();
    logic [2:0]  unit;
    logic [2:0]  part;
    logic [19:0] blk;
    logic [15:0] bytes;
    logic [15:0] curcyl;
    logic [9:0]  look;
    bit          rm;
    int          span, nblk, per_cyl, ns;
    if ($urandom_range(0, 99) < 20) begin
      send_request(3'($urandom), 3'($urandom), 20'($urandom), 16'($urandom),
                   16'($urandom), 10'($urandom));
      return;
    end
    unit = 3'($urandom_range(0, UNIT_COUNT - 1));
    rm   = (unit == 3'd0) ? geo0 : geo1;
    do part = 3'($urandom); while (part_blocks(rm, part) == 0);
    span    = int'(part_blocks(rm, part));
    per_cyl = rm ? NRMSECT * NRMTRAC : NSECT * NTRAC;
    ns      = rm ? NRMSECT : NSECT;
    case ($urandom_range(0, 3))
      0:       bytes = 16'd0;
      1:       bytes = 16'($urandom_range(1, 2048));
      2:       bytes = 16'($urandom);
      default: bytes = 16'($urandom_range(0, 127) * 512);
    endcase
    nblk = (int'(bytes) + 511) >> 9;
    // mostly inside the partition, sometimes right at or just past its end
    if ($urandom_range(0, 9) < 8)
      blk = 20'($urandom_range(0, span - nblk));
    else
      blk = 20'(span - nblk + $urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0, 1, 2: curcyl = 16'(int'(blk) / per_cyl + part_base(rm, part));
      3:       curcyl = 16'(int'(blk) / per_cyl + part_base(rm, part)
                            + $urandom_range(0, 2) - 1);
      default: curcyl = 16'($urandom);
    endcase
    look = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, ns + 3)) : 10'($urandom);
    send_request(unit, part, blk, bytes, curcyl, look);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) rush = ($urandom_range(0, 3) == 0);
      random_request();
    end
    rush = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_UNIT0_IS_RM;
    cfg_data  = 1'b0;
    issued    = 0;
    cycles    = 0;
    rush      = 1'b0;
    geo0      = 1'b0;
    geo1      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // both drives of the 22x19 type after reset
    send_request(3'd7, 3'd0, 20'd0, 16'd0, 16'd0, 10'd0);
    send_request(3'd2, 3'd3, 20'd100, 16'd512, 16'd0, 10'd5);
    send_request(3'd0, 3'd0, 20'hFFFFF, 16'd0, 16'd0, 10'd0);
    send_request(3'd0, 3'd0, 20'h80000, 16'd512, 16'd0, 10'd0);
    send_request(3'd0, 3'd0, 20'd9613, 16'd512, 16'd22, 10'h3FF);
    send_request(3'd0, 3'd0, 20'd9613, 16'd513, 16'd0, 10'd0);
    send_request(3'd0, 3'd0, 20'd9614, 16'd0, 16'd0, 10'd0);
    send_request(3'd0, 3'd4, 20'd0, 16'd0, 16'd0, 10'd0);
    send_request(3'd0, 3'd4, 20'd0, 16'd1, 16'd0, 10'd0);
    send_request(3'd1, 3'd3, 20'd0, 16'hFFFF, 16'd130, 10'd0);
    send_request(3'd1, 3'd7, 20'h7FFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
    // walk the head across the edges of the rotational window
    send_request(3'd0, 3'd0, 20'd5, 16'd0, 16'd0, 10'd2);
    send_request(3'd0, 3'd0, 20'd5, 16'd0, 16'd0, 10'd18);
    send_request(3'd0, 3'd0, 20'd5, 16'd0, 16'd0, 10'd19);
    send_request(3'd0, 3'd0, 20'd5, 16'd0, 16'd0, 10'd0);
    send_request(3'd0, 3'd3, 20'd286329, 16'd1, 16'd815, 10'd0);
    send_request(3'd1, 3'd6, 20'd0, 16'd0, 16'hFFFF, 10'd0);
    send_request(3'd0, 3'd0, 20'd0, 16'd0, 16'd0, 10'd0);
    random_phase(RANDOM_PER_PHASE);

    write_geometry(1'b1, 1'b1);
    send_request(3'd0, 3'd2, 20'd0, 16'd0, 16'd0, 10'd0);
    send_request(3'd1, 3'd7, 20'd113279, 16'd512, 16'd822, 10'd0);
    send_request(3'd0, 3'd1, 20'd7, 16'd0, 16'd60, 10'd5);
    send_request(3'd1, 3'd1, 20'd7, 16'd0, 16'd60, 10'd31);
    send_request(3'd0, 3'd0, 20'd9600, 16'd1, 16'd0, 10'd0);
    send_request(3'd2, 3'd0, 20'd0, 16'd0, 16'd0, 10'd0);
    random_phase(RANDOM_PER_PHASE);

    write_geometry(1'b1, 1'b0);
    random_phase(RANDOM_PER_PHASE);

    write_geometry(1'b0, 1'b1);
    random_phase(RANDOM_PER_PHASE);

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
